// ===== src/vebtc_pkg.sv =====
package vebtc_pkg;

    localparam int HISTORY_DEPTH_DEFAULT  = 8;
    localparam int CAPTURE_FRAMES_DEFAULT = 16;
    localparam int QUEUE_DEPTH            = 2;

    localparam logic [11:0] RATIO_RESET  = 12'd384;
    localparam logic [15:0] WINDOW_RESET = 16'd8;

    // Register indexes on the configuration port.
    localparam logic REG_EXPANSION_RATIO = 1'b0;
    localparam logic REG_WINDOW_FRAMES   = 1'b1;

    // Interval reported when the presented interval is not finite: -1.0 in Q.10.
    localparam logic [31:0] NO_INTERVAL = 32'hFFFF_FC00;

    typedef struct packed {
        logic [31:0] frame;
        logic        seen;
        logic [23:0] width;
        logic [23:0] height;
        logic [31:0] interval;
        logic [31:0] render;
    } cap_sample_t;

    typedef struct packed {
        logic [15:0] event_number;
        logic [23:0] baseline_width;
        logic [23:0] baseline_height;
        logic [23:0] trigger_width;
        logic [23:0] trigger_height;
    } cap_header_t;

    typedef struct packed {
        cap_header_t hdr;
        cap_sample_t smp;
        logic        first;
        logic        final_word;
    } queue_rec_t;

    typedef struct packed {
        logic [31:0] frame;
        logic [23:0] width;
        logic [23:0] height;
    } hist_entry_t;

endpackage

// ===== src/view_expansion_burst_trigger_capture_core.sv =====
// View expansion burst trigger and capture. One input word arrives per displayed
// frame; the front end takes a frame through idle, rearm and update states, a push
// state when the frame yields a sample, and a read and a check state for each
// history entry it examines, reading one entry at a time from its history RAM.
// While armed, valid views are kept in a
// history; a frame whose width and height have each reached the programmed
// ratio times an entry at most window_frames back starts a capture of
// CAPTURE_FRAMES samples. Samples go through a two-word queue to the back end,
// which stores them and, on the sample that fills the capture, plays all of them
// out, reading each from its store and then loading it into the output register,
// tlast marking the final one. The front end keeps taking frames while the back
// end plays out, until the queue fills. Configuration is to be written only while
// the block is idle; the block itself does not enforce this.
module view_expansion_burst_trigger_capture_core #(
    parameter int HISTORY_DEPTH  = vebtc_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int CAPTURE_FRAMES = vebtc_pkg::CAPTURE_FRAMES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame[31:0], view_seen[32], view_width[56:33], view_height[80:57],
    // render_ms[112:81], interval_ms[143:113], interval_valid[144], zeros above.
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // event_number[15:0], baseline_width[39:16], baseline_height[63:40],
    // trigger_width[87:64], trigger_height[111:88], sample_frame[143:112],
    // sample_view_seen[144], sample_width[168:145], sample_height[192:169],
    // sample_interval[224:193], sample_render[256:225], zeros above.
    output logic [263:0] m_tdata,
    output logic         m_tlast
);

    logic [11:0]            ratio_reg;
    logic [15:0]            window_reg;
    logic                   q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    vebtc_pkg::queue_rec_t  q_push_data, q_pop_data;
    vebtc_pkg::cap_header_t out_hdr;
    vebtc_pkg::cap_sample_t out_smp;

    // Configuration registers: written directly, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= vebtc_pkg::RATIO_RESET;
            window_reg <= vebtc_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vebtc_pkg::REG_EXPANSION_RATIO: ratio_reg  <= cfg_data[11:0];
                vebtc_pkg::REG_WINDOW_FRAMES:   window_reg <= cfg_data;
                default:                        ratio_reg  <= ratio_reg;
            endcase
        end
    end

    // The front end detects the trigger and forms one sample per captured frame.
    vebtc_front #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .CAPTURE_FRAMES (CAPTURE_FRAMES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .ratio          (ratio_reg),
        .window         (window_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .frame          (s_tdata[31:0]),
        .view_seen      (s_tdata[32]),
        .view_width     (s_tdata[56:33]),
        .view_height    (s_tdata[80:57]),
        .render_ms      (s_tdata[112:81]),
        .interval_ms    (s_tdata[143:113]),
        .interval_valid (s_tdata[144]),
        .push_valid     (q_push_valid),
        .push_ready     (q_push_ready),
        .push_data      (q_push_data)
    );

    vebtc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // The back end stores the capture and plays it out once it is complete.
    vebtc_back #(
        .CAPTURE_FRAMES (CAPTURE_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hdr   (out_hdr),
        .out_smp   (out_smp),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'b0,
                      out_smp.render, out_smp.interval, out_smp.height, out_smp.width,
                      out_smp.seen, out_smp.frame,
                      out_hdr.trigger_height, out_hdr.trigger_width,
                      out_hdr.baseline_height, out_hdr.baseline_width,
                      out_hdr.event_number};

endmodule

// ===== src/vebtc_ram.sv =====
module vebtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/vebtc_queue.sv =====
module vebtc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  vebtc_pkg::queue_rec_t  push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output vebtc_pkg::queue_rec_t  pop_data
);

    localparam int PW = (vebtc_pkg::QUEUE_DEPTH > 1) ? $clog2(vebtc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(vebtc_pkg::QUEUE_DEPTH + 1);

    vebtc_pkg::queue_rec_t entry_reg [vebtc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(vebtc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(vebtc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(vebtc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/vebtc_front.sv =====
module vebtc_front #(
    parameter int HISTORY_DEPTH  = vebtc_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int CAPTURE_FRAMES = vebtc_pkg::CAPTURE_FRAMES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [11:0]            ratio,
    input  logic [15:0]            window,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            frame,
    input  logic                   view_seen,
    input  logic [23:0]            view_width,
    input  logic [23:0]            view_height,
    input  logic [31:0]            render_ms,
    input  logic [30:0]            interval_ms,
    input  logic                   interval_valid,
    output logic                   push_valid,
    input  logic                   push_ready,
    output vebtc_pkg::queue_rec_t  push_data
);

    localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW  = HCW + 1;
    localparam int KW  = $clog2(CAPTURE_FRAMES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REARM  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_PUSH   = 3'd5;

    logic [2:0]              state_reg, state_next;
    vebtc_pkg::cap_sample_t  smp_reg, smp_next;
    logic                    armed_reg, armed_next;
    logic [23:0]             rearm_w_reg, rearm_w_next, rearm_h_reg, rearm_h_next;
    logic [23:0]             known_w_reg, known_w_next, known_h_reg, known_h_next;
    logic [HW-1:0]           base_reg, base_next;
    logic [HCW-1:0]          hcount_reg, hcount_next;
    logic [HCW-1:0]          scan_reg, scan_next;
    logic                    capturing_reg, capturing_next;
    logic [15:0]             event_reg, event_next;
    logic [KW-1:0]           ccount_reg, ccount_next;
    logic                    found_reg, found_next;
    logic [23:0]             bw_reg, bw_next, bh_reg, bh_next;
    vebtc_pkg::queue_rec_t   rec_reg, rec_next;

    logic                    have;
    logic [35:0]             cw_scaled, ch_scaled;
    logic [35:0]             rw_prod, rh_prod, hw_prod, hh_prod;
    logic                    rearm_hit, armed_eff, hist_hit;
    logic [HCW-1:0]          hcount_eff;
    logic [SW-1:0]           rd_sum, wr_sum, base_sum;
    logic [HW-1:0]           rd_addr, wr_addr;
    logic                    wr_en;
    vebtc_pkg::hist_entry_t  rd_entry, wr_entry;
    logic [31:0]             frame_gap;
    logic                    cap_eff, last_sample;
    logic [KW-1:0]           ccount_eff;

    vebtc_ram #(
        .WIDTH ($bits(vebtc_pkg::hist_entry_t)),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = rec_reg;
    assign have       = view_seen && (view_width != '0) && (view_height != '0);

    assign cw_scaled = {4'b0, smp_reg.width, 8'b0};
    assign ch_scaled = {4'b0, smp_reg.height, 8'b0};
    assign rw_prod   = 36'(rearm_w_reg) * 36'(ratio);
    assign rh_prod   = 36'(rearm_h_reg) * 36'(ratio);
    assign hw_prod   = 36'(rd_entry.width) * 36'(ratio);
    assign hh_prod   = 36'(rd_entry.height) * 36'(ratio);
    assign rearm_hit = !armed_reg && smp_reg.seen && (cw_scaled < rw_prod) && (ch_scaled < rh_prod);
    assign frame_gap = smp_reg.frame - rd_entry.frame;
    assign hist_hit  = (smp_reg.frame > rd_entry.frame) && (frame_gap <= {16'b0, window})
                       && (cw_scaled >= hw_prod) && (ch_scaled >= hh_prod);

    // Newest entry of the scan sits at base + scan - 1, modulo the depth.
    assign rd_sum  = SW'(base_reg) + SW'(scan_reg) - SW'(1);
    assign rd_addr = (rd_sum >= SW'(HISTORY_DEPTH)) ? HW'(rd_sum - SW'(HISTORY_DEPTH)) : HW'(rd_sum);

    always_comb
    begin
        state_next     = state_reg;
        smp_next       = smp_reg;
        armed_next     = armed_reg;
        rearm_w_next   = rearm_w_reg;
        rearm_h_next   = rearm_h_reg;
        known_w_next   = known_w_reg;
        known_h_next   = known_h_reg;
        base_next      = base_reg;
        hcount_next    = hcount_reg;
        scan_next      = scan_reg;
        capturing_next = capturing_reg;
        event_next     = event_reg;
        ccount_next    = ccount_reg;
        found_next     = found_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        rec_next       = rec_reg;
        armed_eff      = armed_reg;
        hcount_eff     = hcount_reg;
        wr_en          = 1'b0;
        wr_sum         = '0;
        base_sum       = '0;
        wr_addr        = '0;
        wr_entry       = '{frame: smp_reg.frame, width: smp_reg.width, height: smp_reg.height};
        cap_eff        = 1'b0;
        ccount_eff     = '0;
        last_sample    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next.frame    = frame;
                    smp_next.seen     = have;
                    smp_next.width    = have ? view_width : known_w_reg;
                    smp_next.height   = have ? view_height : known_h_reg;
                    smp_next.interval = interval_valid ? {1'b0, interval_ms}
                                                       : vebtc_pkg::NO_INTERVAL;
                    smp_next.render   = render_ms;
                    found_next        = 1'b0;
                    state_next        = ST_REARM;
                end
            end

            ST_REARM:
            begin
                if (rearm_hit)
                begin
                    armed_eff  = 1'b1;
                    hcount_eff = '0;
                end
                armed_next  = armed_eff;
                hcount_next = hcount_eff;
                scan_next   = hcount_eff;
                if (armed_eff && !capturing_reg && smp_reg.seen && (hcount_eff != '0))
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (hist_hit)
                begin
                    found_next = 1'b1;
                    bw_next    = rd_entry.width;
                    bh_next    = rd_entry.height;
                    state_next = ST_UPDATE;
                end
                else if (scan_reg == HCW'(1))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    scan_next  = scan_reg - 1'b1;
                    state_next = ST_READ;
                end
            end

            ST_UPDATE:
            begin
                if (found_reg)
                begin
                    armed_eff    = 1'b0;
                    hcount_eff   = '0;
                    rearm_w_next = bw_reg;
                    rearm_h_next = bh_reg;
                    event_next   = event_reg + 1'b1;
                end
                armed_next  = armed_eff;
                hcount_next = hcount_eff;
                if (smp_reg.seen)
                begin
                    known_w_next = smp_reg.width;
                    known_h_next = smp_reg.height;
                    if (armed_eff)
                    begin
                        wr_en = 1'b1;
                        if (hcount_eff == HCW'(HISTORY_DEPTH))
                        begin
                            // Full: the oldest slot takes the new entry.
                            wr_addr  = base_reg;
                            base_sum = SW'(base_reg) + SW'(1);
                            base_next = (base_sum >= SW'(HISTORY_DEPTH))
                                        ? HW'(base_sum - SW'(HISTORY_DEPTH)) : HW'(base_sum);
                        end
                        else
                        begin
                            wr_sum      = SW'(base_reg) + SW'(hcount_eff);
                            wr_addr     = (wr_sum >= SW'(HISTORY_DEPTH))
                                          ? HW'(wr_sum - SW'(HISTORY_DEPTH)) : HW'(wr_sum);
                            hcount_next = hcount_eff + 1'b1;
                        end
                    end
                end

                cap_eff     = capturing_reg || found_reg;
                ccount_eff  = found_reg ? '0 : ccount_reg;
                last_sample = (ccount_eff == KW'(CAPTURE_FRAMES - 1));
                rec_next.smp        = smp_reg;
                rec_next.first      = found_reg;
                rec_next.final_word = last_sample;
                rec_next.hdr        = '{event_number:    event_reg,
                                        baseline_width:  bw_reg,
                                        baseline_height: bh_reg,
                                        trigger_width:   smp_reg.width,
                                        trigger_height:  smp_reg.height};
                if (cap_eff)
                begin
                    capturing_next = !last_sample;
                    ccount_next    = last_sample ? '0 : ccount_eff + 1'b1;
                    state_next     = ST_PUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= 1'b1;
            rearm_w_reg   <= '0;
            rearm_h_reg   <= '0;
            known_w_reg   <= '0;
            known_h_reg   <= '0;
            base_reg      <= '0;
            hcount_reg    <= '0;
            scan_reg      <= '0;
            capturing_reg <= 1'b0;
            event_reg     <= '0;
            ccount_reg    <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            rearm_w_reg   <= rearm_w_next;
            rearm_h_reg   <= rearm_h_next;
            known_w_reg   <= known_w_next;
            known_h_reg   <= known_h_next;
            base_reg      <= base_next;
            hcount_reg    <= hcount_next;
            scan_reg      <= scan_next;
            capturing_reg <= capturing_next;
            event_reg     <= event_next;
            ccount_reg    <= ccount_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        bw_reg  <= bw_next;
        bh_reg  <= bh_next;
        rec_reg <= rec_next;
    end

endmodule

// ===== src/vebtc_back.sv =====
module vebtc_back #(
    parameter int CAPTURE_FRAMES = vebtc_pkg::CAPTURE_FRAMES_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  vebtc_pkg::queue_rec_t   pop_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vebtc_pkg::cap_header_t  out_hdr,
    output vebtc_pkg::cap_sample_t  out_smp,
    output logic                    out_last
);

    localparam int CW = (CAPTURE_FRAMES > 1) ? $clog2(CAPTURE_FRAMES) : 1;

    localparam logic [1:0] ST_TAKE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           wr_idx_reg, wr_idx_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    vebtc_pkg::cap_header_t  hdr_reg, hdr_next;
    logic                    ov_reg, ov_next;
    vebtc_pkg::cap_header_t  ohdr_reg, ohdr_next;
    vebtc_pkg::cap_sample_t  osmp_reg, osmp_next;
    logic                    olast_reg, olast_next;
    logic                    wr_en;
    vebtc_pkg::cap_sample_t  rd_smp;
    logic                    rd_final;

    vebtc_ram #(
        .WIDTH ($bits(vebtc_pkg::cap_sample_t)),
        .DEPTH (CAPTURE_FRAMES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (pop_data.smp),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_smp)
    );

    assign pop_ready = (state_reg == ST_TAKE);
    assign wr_en     = pop_valid && pop_ready;
    assign rd_final  = (rd_idx_reg == CW'(CAPTURE_FRAMES - 1));
    assign out_valid = ov_reg;
    assign out_hdr   = ohdr_reg;
    assign out_smp   = osmp_reg;
    assign out_last  = olast_reg;

    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        hdr_next    = hdr_reg;
        ov_next     = ov_reg && !out_ready;
        ohdr_next   = ohdr_reg;
        osmp_next   = osmp_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_TAKE:
            begin
                if (pop_valid)
                begin
                    if (pop_data.first)
                    begin
                        hdr_next = pop_data.hdr;
                    end
                    if (pop_data.final_word)
                    begin
                        wr_idx_next = '0;
                        rd_idx_next = '0;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ohdr_next  = hdr_reg;
                    osmp_next  = rd_smp;
                    olast_next = rd_final;
                    if (rd_final)
                    begin
                        state_next = ST_TAKE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_TAKE;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg   <= hdr_next;
        ohdr_reg  <= ohdr_next;
        osmp_reg  <= osmp_next;
        olast_reg <= olast_next;
    end

endmodule
